[src/sidf_pkg.sv]
// ----------------------------------------------------------------------------
// sidf_pkg
// Shared constants, types and the letter table for the sequential ID
// formatter.
// ----------------------------------------------------------------------------
package sidf_pkg;

  localparam int MAX_GROUPS  = 9;
  localparam int GRP_IDX_W   = $clog2(MAX_GROUPS);
  localparam int GRP_CNT_W   = $clog2(MAX_GROUPS + 1);

  localparam int CNT_W       = 64;
  localparam int CHUNK_W     = 16;
  localparam int NUM_CHUNKS  = CNT_W / CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);

  localparam int DIGIT_W     = 8;
  localparam int RADIX       = 171;
  localparam int STEP_W      = DIGIT_W + CHUNK_W;

  // floor(x / 171) == (x * RECIP) >> RECIP_SHIFT, exact for x < 2^24
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_W     = 33;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd170) / 64'd171);

  localparam int CHAR_W      = 8;
  localparam int LETTER_IDX_W = 5;

  localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ONE  = 8'h31;
  localparam logic [CHAR_W-1:0] CH_Z    = 8'h5A;

  // one step of the long division: quotient chunk and running remainder
  typedef struct packed {
    logic [CHUNK_W-1:0] quo;
    logic [DIGIT_W-1:0] rem;
  } div_step_t;

  function automatic logic [CHAR_W-1:0] letter_code(input logic [LETTER_IDX_W-1:0] idx);
    logic [CHAR_W-1:0] ch;
    case (idx)
      5'd0:    ch = 8'h41; // A
      5'd1:    ch = 8'h42; // B
      5'd2:    ch = 8'h43; // C
      5'd3:    ch = 8'h45; // E
      5'd4:    ch = 8'h48; // H
      5'd5:    ch = 8'h49; // I
      5'd6:    ch = 8'h4B; // K
      5'd7:    ch = 8'h4C; // L
      5'd8:    ch = 8'h4E; // N
      5'd9:    ch = 8'h4F; // O
      5'd10:   ch = 8'h50; // P
      5'd11:   ch = 8'h52; // R
      5'd12:   ch = 8'h53; // S
      5'd13:   ch = 8'h54; // T
      5'd14:   ch = 8'h55; // U
      5'd15:   ch = 8'h57; // W
      5'd16:   ch = 8'h58; // X
      5'd17:   ch = 8'h59; // Y
      default: ch = CH_Z;
    endcase
    return ch;
  endfunction

endpackage

[src/sidf_div171.sv]
// ----------------------------------------------------------------------------
// sidf_div171
// One 16-bit step of a long division by 171: {rem, chunk} -> quo, rem.
// ----------------------------------------------------------------------------
module sidf_div171 (
  input  logic [sidf_pkg::DIGIT_W-1:0] rem_in,
  input  logic [sidf_pkg::CHUNK_W-1:0] chunk,
  output sidf_pkg::div_step_t          res
);
  import sidf_pkg::*;

  logic [STEP_W-1:0]           x;
  logic [STEP_W+RECIP_W-1:0]   prod;
  logic [CHUNK_W-1:0]          q;
  logic [STEP_W-1:0]           r;

  // rem_in < 171 keeps the quotient within 16 bits
  assign x    = {rem_in, chunk};
  assign prod = (STEP_W + RECIP_W)'(x) * (STEP_W + RECIP_W)'(RECIP);
  assign q    = prod[RECIP_SHIFT +: CHUNK_W];
  assign r    = x - STEP_W'(STEP_W'(q) * STEP_W'(RADIX));

  assign res.quo = q;
  assign res.rem = r[DIGIT_W-1:0];

endmodule

[src/sidf_char_enc.sv]
// ----------------------------------------------------------------------------
// sidf_char_enc
// Maps one base-171 digit to its letter and numeral characters.
// ----------------------------------------------------------------------------
module sidf_char_enc (
  input  logic [sidf_pkg::DIGIT_W-1:0] digit,
  output logic [sidf_pkg::CHAR_W-1:0]  letter,
  output logic [sidf_pkg::CHAR_W-1:0]  numeral
);
  import sidf_pkg::*;

  logic [13:0]             prod;
  logic [LETTER_IDX_W-1:0] li;
  logic [DIGIT_W-1:0]      lo;

  // digit / 9 as (digit * 57) >> 9, exact for digit < 171
  assign prod    = 14'(digit) * 14'd57;
  assign li      = prod[13:9];
  assign lo      = digit - DIGIT_W'(DIGIT_W'(li) * DIGIT_W'(9));
  assign letter  = letter_code(li);
  assign numeral = CH_ONE + CHAR_W'(lo);

endmodule

[src/sequential_id_formatter_unit.sv]
// ----------------------------------------------------------------------------
// sequential_id_formatter_unit
// Counter that renders each increment as a bijective base-171 identifier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_kind = 0 loads in_load_value into
//   the 64-bit counter and produces nothing. in_kind = 1 bumps the counter
//   (64-bit wrap) and spells counter+1 as groups "<letter><1-9>" joined by
//   '-', most significant group first.
//   Output channel (out_valid/out_ready): one ASCII character per word,
//   out_last set on the final character. Up to 26 words per identifier.
//   A load is handled in the idle state. An increment with d groups runs
//   each digit through the shared divide-by-171 unit (four 16-bit steps
//   per digit plus one step to decrement the quotient), then emits 3*d - 1
//   characters at one per cycle when the receiver keeps out_ready high.
//   in_ready is high only while the sequencer is idle; the last character
//   may still sit in the output register while the next word is taken.
//   Receiver stall: the sequencer simply holds until the output register
//   frees; nothing is dropped.
//   Reset: counter cleared to zero, sequencer idle, output empty.
// ----------------------------------------------------------------------------
module sequential_id_formatter_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [sidf_pkg::CNT_W-1:0]   in_load_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sidf_pkg::CHAR_W-1:0]  out_char_code,
  output logic                         out_last
);
  import sidf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_NEXT, S_EMIT} state_t;
  typedef enum logic [1:0] {P_LETTER, P_NUMERAL, P_DASH} phase_t;

  state_t                  state_r, state_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [CNT_W-1:0]        counter_r, counter_nxt;
  logic [CNT_W-1:0]        work_r, work_nxt;      // dividend, shifted into quotient
  logic [DIGIT_W-1:0]      rem_r, rem_nxt;
  logic [CHUNK_IDX_W-1:0]  chunk_cnt_r, chunk_cnt_nxt;
  logic [GRP_CNT_W-1:0]    digit_cnt_r, digit_cnt_nxt;
  logic [GRP_IDX_W-1:0]    emit_idx_r, emit_idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]       out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;

  // digits of the current identifier, least significant first
  logic [DIGIT_W-1:0]      digit_store [MAX_GROUPS];
  logic                    store_we;

  div_step_t               step;
  logic [DIGIT_W-1:0]      cur_digit;
  logic [CHAR_W-1:0]       letter;
  logic [CHAR_W-1:0]       numeral;
  logic                    out_slot;
  logic                    in_fire;
  logic [CNT_W-1:0]        counter_inc;

  // shared divide unit: top chunk of the working word against the remainder
  sidf_div171 u_div (
    .rem_in (rem_r),
    .chunk  (work_r[CNT_W-1 -: CHUNK_W]),
    .res    (step)
  );

  assign cur_digit = digit_store[emit_idx_r];

  sidf_char_enc u_enc (
    .digit   (cur_digit),
    .letter  (letter),
    .numeral (numeral)
  );

  assign in_ready      = (state_r == S_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;
  assign out_slot      = !out_valid_r || out_ready;
  assign counter_inc   = counter_r + CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    counter_nxt   = counter_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    chunk_cnt_nxt = chunk_cnt_r;
    digit_cnt_nxt = digit_cnt_r;
    emit_idx_nxt  = emit_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    store_we      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_kind) begin
            counter_nxt = in_load_value;
          end else begin
            // first digit comes straight from the bumped counter
            counter_nxt   = counter_inc;
            work_nxt      = counter_inc;
            rem_nxt       = '0;
            chunk_cnt_nxt = '0;
            digit_cnt_nxt = '0;
            state_nxt     = S_DIV;
          end
        end
      end

      S_DIV: begin
        work_nxt      = {work_r[CNT_W-CHUNK_W-1:0], step.quo};
        rem_nxt       = step.rem;
        chunk_cnt_nxt = chunk_cnt_r + CHUNK_IDX_W'(1);
        if (chunk_cnt_r == CHUNK_IDX_W'(NUM_CHUNKS - 1)) begin
          store_we      = 1'b1;
          digit_cnt_nxt = digit_cnt_r + GRP_CNT_W'(1);
          state_nxt     = S_NEXT;
        end
      end

      S_NEXT: begin
        if ((work_r != '0) && (digit_cnt_r < GRP_CNT_W'(MAX_GROUPS))) begin
          // bijective step: continue with quotient - 1
          work_nxt      = work_r - CNT_W'(1);
          rem_nxt       = '0;
          chunk_cnt_nxt = '0;
          state_nxt     = S_DIV;
        end else begin
          emit_idx_nxt = GRP_IDX_W'(digit_cnt_r - GRP_CNT_W'(1));
          phase_nxt    = P_LETTER;
          state_nxt    = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_slot) begin
          out_valid_nxt = 1'b1;
          case (phase_r)
            P_LETTER: begin
              out_char_nxt = letter;
              out_last_nxt = 1'b0;
              phase_nxt    = P_NUMERAL;
            end
            P_NUMERAL: begin
              out_char_nxt = numeral;
              out_last_nxt = (emit_idx_r == '0);
              if (emit_idx_r == '0) begin
                state_nxt = S_IDLE;
              end else begin
                phase_nxt = P_DASH;
              end
            end
            P_DASH: begin
              out_char_nxt = CH_DASH;
              out_last_nxt = 1'b0;
              emit_idx_nxt = emit_idx_r - GRP_IDX_W'(1);
              phase_nxt    = P_LETTER;
            end
            default: begin
              out_valid_nxt = 1'b0;
              phase_nxt     = P_LETTER;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= P_LETTER;
      counter_r   <= '0;
      chunk_cnt_r <= '0;
      digit_cnt_r <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      counter_r   <= counter_nxt;
      chunk_cnt_r <= chunk_cnt_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (store_we) begin
      digit_store[digit_cnt_r[GRP_IDX_W-1:0]] <= step.rem;
    end
  end

endmodule
